/* hdl/datediff_pkg.sv */
// ----------------------------------------------------------------------------
// datediff_pkg
// Widths, constants and calendar tables for the date difference unit.
// ----------------------------------------------------------------------------
package datediff_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 22;
  localparam int DOY_W   = 9;
  localparam int SPAN_W  = 24;
  localparam int SUM_W   = SPAN_W + 1;

  // shared multiplier: a 14-bit year times a 13-bit constant
  localparam int MULK_W = 13;
  localparam int MUL_W  = YEAR_W + MULK_W;

  // divide by 100 as a multiply by 2^19/100 rounded up, exact for 14-bit years
  localparam int REM_W       = 7;
  localparam int QUO_W       = 8;
  localparam int RECIP_SHIFT = 19;
  localparam logic [MULK_W-1:0] RECIP_CENTURY = 13'd5243;
  localparam logic [REM_W-1:0]  CENTURY       = 7'd100;
  localparam logic [REM_W-1:0]  CENTURY_LAST  = 7'd99;

  localparam logic [DOY_W-1:0] COMMON_YEAR_DAYS = 9'd365;
  localparam logic [DOY_W-1:0] LEAP_YEAR_DAYS   = 9'd366;
  localparam logic [COUNT_W-1:0] DAY_COUNT_MAX  = 22'd4194303;
  localparam logic [MULK_W-1:0] DAYS_PER_YEAR_MUL = 13'd365;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // days before the first of a month, month index 0 is january
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] mi,
                                                   input logic leap);
    logic [DOY_W-1:0] base;
    logic [DOY_W-1:0] adj;
    begin
      unique case (mi)
        4'd0:    base = 9'd0;
        4'd1:    base = 9'd31;
        4'd2:    base = 9'd59;
        4'd3:    base = 9'd90;
        4'd4:    base = 9'd120;
        4'd5:    base = 9'd151;
        4'd6:    base = 9'd181;
        4'd7:    base = 9'd212;
        4'd8:    base = 9'd243;
        4'd9:    base = 9'd273;
        4'd10:   base = 9'd304;
        default: base = 9'd334;
      endcase
      adj = (leap && (mi >= 4'd2)) ? 9'd1 : 9'd0;
      days_before = base + adj;
    end
  endfunction

  // 1-based day of year, month clamped to january..december
  function automatic logic [DOY_W-1:0] day_of_year(input logic [DAY_W-1:0] d,
                                                   input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [MONTH_W-1:0] mc;
    begin
      if (m < MONTH_JAN) mc = MONTH_JAN;
      else if (m > MONTH_DEC) mc = MONTH_DEC;
      else mc = m;
      day_of_year = days_before(mc - MONTH_JAN, leap) + DOY_W'(d);
    end
  endfunction

endpackage

/* hdl/date_difference_days_unit.sv */
// ----------------------------------------------------------------------------
// date_difference_days_unit
// Absolute number of days between two Gregorian dates.
// ----------------------------------------------------------------------------
// One input beat gives one result beat. The two dates are ordered, then one
// shared multiplier is used in turn: two divide-by-100 passes through a
// reciprocal product, first on the earlier year, then on the year before the
// later one, each pass forming the quotient first and then the remainder;
// the quotients and remainders give the leap flags and the century terms.
// The same multiplier then forms 365 times the year gap in S_CALC, S_SPAN
// adds the leap days and S_SUM forms the sum and loads it into the output
// register. The input is ready again once the result sits in the output
// register, so the unit takes no new item while one is still in progress;
// a new item is accepted while a finished result still waits in the output
// register and then holds in its last step until that register is free.
// Years 0..16383, month 0 reads as january and above 12 as december, days are
// used as given; the count saturates at the top of the 22-bit field.
module date_difference_days_unit import datediff_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [DAY_W-1:0]   day_a,
  input  logic [MONTH_W-1:0] month_a,
  input  logic [YEAR_W-1:0]  year_a,
  input  logic [DAY_W-1:0]   day_b,
  input  logic [MONTH_W-1:0] month_b,
  input  logic [YEAR_W-1:0]  year_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COUNT_W-1:0] day_count
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV1 = 3'd1;
  localparam logic [2:0] S_DIV2 = 3'd2;
  localparam logic [2:0] S_CALC = 3'd3;
  localparam logic [2:0] S_SPAN = 3'd4;
  localparam logic [2:0] S_SUM  = 3'd5;

  logic [2:0] state;
  logic       phase;

  // ordered dates
  logic [DAY_W-1:0]   d1, d2;
  logic [MONTH_W-1:0] m1, m2;
  logic [YEAR_W-1:0]  y1, y2;

  // shared multiplier and the divide by 100 built on it
  logic [YEAR_W-1:0] dq;
  logic [MULK_W-1:0] mul_k;
  logic [MUL_W-1:0]  prod;
  logic [QUO_W-1:0]  quo, quo_next;
  logic [REM_W-1:0]  rem, rem_next;

  logic [QUO_W-1:0] q1;
  logic [REM_W-1:0] r1;

  // calc results
  logic [SPAN_W-1:0] span;
  logic [DOY_W-1:0]  doy1, doy2, len1;
  logic              same_year;

  logic in_fire, swap, out_load;
  logic [YEAR_W+MONTH_W+DAY_W-1:0] key1, key2;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign key1 = {year_a, month_a, day_a};
  assign key2 = {year_b, month_b, day_b};
  assign swap = key2 < key1;

  always_comb begin
    mul_k    = (state == S_CALC) ? DAYS_PER_YEAR_MUL : RECIP_CENTURY;
    prod     = MUL_W'(dq) * MUL_W'(mul_k);
    quo_next = prod[RECIP_SHIFT +: QUO_W];
    rem_next = REM_W'(dq - YEAR_W'(quo) * YEAR_W'(CENTURY));
  end

  // calc stage terms
  logic [YEAR_W-1:0] ym;
  logic              leap1, leap2;
  logic [SPAN_W-1:0] span_next;

  always_comb begin
    ym    = y2 - YEAR_W'(1);
    leap1 = (r1 == '0) ? (q1[1:0] == 2'd0) : (y1[1:0] == 2'd0);
    // later year from the year before it: a carry into the next century
    leap2 = (rem == CENTURY_LAST) ? (quo[1:0] == 2'd3) : (y2[1:0] == 2'd0);
    // leap days of the full years between
    span_next = span
              + SPAN_W'(ym >> 2) - SPAN_W'(y1 >> 2)
              + SPAN_W'(q1) - SPAN_W'(quo)
              + SPAN_W'(quo >> 2) - SPAN_W'(q1 >> 2);
  end

  // final sum
  logic [SUM_W-1:0]   total;
  logic [COUNT_W-1:0] count_next;

  always_comb begin
    total = SUM_W'(len1) - SUM_W'(doy1) + SUM_W'(doy2) + SUM_W'(span);
    if (same_year) begin
      count_next = (doy2 >= doy1) ? COUNT_W'(doy2 - doy1) : COUNT_W'(doy1 - doy2);
    end else if (total[SUM_W-1] || (total[SUM_W-2:COUNT_W] != '0)) begin
      count_next = DAY_COUNT_MAX;
    end else begin
      count_next = total[COUNT_W-1:0];
    end
  end

  assign out_load = (state == S_SUM) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= S_DIV1;
            phase <= 1'b0;
          end
        end
        S_DIV1: begin
          phase <= !phase;
          if (phase) state <= S_DIV2;
        end
        S_DIV2: begin
          phase <= !phase;
          if (phase) state <= S_CALC;
        end
        S_CALC: state <= S_SPAN;
        S_SPAN: state <= S_SUM;
        S_SUM: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (swap) begin
        d1 <= day_b;  m1 <= month_b; y1 <= year_b;
        d2 <= day_a;  m2 <= month_a; y2 <= year_a;
        dq <= year_b;
      end else begin
        d1 <= day_a;  m1 <= month_a; y1 <= year_a;
        d2 <= day_b;  m2 <= month_b; y2 <= year_b;
        dq <= year_a;
      end
    end else if (state == S_DIV1) begin
      if (!phase) begin
        quo <= quo_next;
      end else begin
        q1 <= quo;
        r1 <= rem_next;
        dq <= ym;
      end
    end else if (state == S_DIV2) begin
      if (!phase) begin
        quo <= quo_next;
      end else begin
        rem <= rem_next;
        // year gap for the 365-day product
        dq  <= ym - y1;
      end
    end
    if (state == S_CALC) begin
      span      <= prod[SPAN_W-1:0];
      doy1      <= day_of_year(d1, m1, leap1);
      doy2      <= day_of_year(d2, m2, leap2);
      len1      <= leap1 ? LEAP_YEAR_DAYS : COMMON_YEAR_DAYS;
      same_year <= (y1 == y2);
    end else if (state == S_SPAN) begin
      span <= span_next;
    end
    if (out_load) day_count <= count_next;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_rem_below_century: assert property (@(posedge clk) disable iff (rst)
    (state == S_CALC) |-> ((rem < CENTURY) && (r1 < CENTURY)))
    else $error("divider remainder out of range");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (day_count <= DAY_COUNT_MAX))
    else $error("day count out of range");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM) && out_valid && !out_ready |=> (state == S_SUM))
    else $error("result dropped while output full");

endmodule

/* bench/date_difference_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// date_difference_checker
// Watches both channels of the date difference unit, works out the day count
// of every accepted date pair and compares each result beat, in order, with
// the oldest pending count. Hands the error count and the number of counts
// still pending to the bench top.
// ----------------------------------------------------------------------------
module date_difference_checker import datediff_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [DAY_W-1:0]   day_a,
  input  logic [MONTH_W-1:0] month_a,
  input  logic [YEAR_W-1:0]  year_a,
  input  logic [DAY_W-1:0]   day_b,
  input  logic [MONTH_W-1:0] month_b,
  input  logic [YEAR_W-1:0]  year_b,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [COUNT_W-1:0] day_count,
  output int                 errors,
  output int                 awaiting
);

  localparam int unsigned DAYS_BEFORE_COMMON [12] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
  localparam int unsigned DAYS_BEFORE_LEAP [12] =
    '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335};

  logic [COUNT_W-1:0] pending_counts [$];
  logic [COUNT_W-1:0] oldest_count;

  function automatic bit is_leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // 1-based, month clamped to january..december, day taken as given
  function automatic int unsigned ordinal_day(input int unsigned d, input int unsigned m,
                                              input int unsigned y);
    int unsigned mi;
    mi = (m < 1) ? 0 : ((m > 12) ? 11 : m - 1);
    return (is_leap_year(y) ? DAYS_BEFORE_LEAP[mi] : DAYS_BEFORE_COMMON[mi]) + d;
  endfunction

  // days in years 1..y, zero for year zero
  function automatic int unsigned days_through_year(input int unsigned y);
    return 365 * y + y / 4 - y / 100 + y / 400;
  endfunction

  function automatic logic [COUNT_W-1:0] days_apart(
    input logic [DAY_W-1:0] d_a, input logic [MONTH_W-1:0] m_a, input logic [YEAR_W-1:0] y_a,
    input logic [DAY_W-1:0] d_b, input logic [MONTH_W-1:0] m_b, input logic [YEAR_W-1:0] y_b);
    int unsigned de, me, ye, dl, ml, yl, oe, ol, total;
    // order by the raw year/month/day key, not by day of year
    if ({y_b, m_b, d_b} < {y_a, m_a, d_a}) begin
      de = d_b; me = m_b; ye = y_b;
      dl = d_a; ml = m_a; yl = y_a;
    end else begin
      de = d_a; me = m_a; ye = y_a;
      dl = d_b; ml = m_b; yl = y_b;
    end
    oe = ordinal_day(de, me, ye);
    ol = ordinal_day(dl, ml, yl);
    if (ye == yl) begin
      total = (ol >= oe) ? ol - oe : oe - ol;
    end else begin
      total = (is_leap_year(ye) ? 366 : 365) - oe
            + days_through_year(yl - 1) - days_through_year(ye) + ol;
    end
    if (total > DAY_COUNT_MAX) total = DAY_COUNT_MAX;
    return COUNT_W'(total);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pending_counts.delete();
      awaiting = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_counts.size() == 0) begin
          $error("day_count: unexpected result %0d with nothing pending", day_count);
          errors++;
        end else begin
          oldest_count = pending_counts.pop_front();
          if (day_count !== oldest_count) begin
            $error("day_count: expected %0d, actual %0d", oldest_count, day_count);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_counts = {pending_counts, days_apart(day_a, month_a, year_a,
                                                     day_b, month_b, year_b)};
      end
      awaiting = pending_counts.size();
    end
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives date pairs into the date difference unit: a directed set of calendar
// corner cases, then random pairs (same year, neighbor years, century leap
// boundaries, wide spans and raw field noise) under three idling profiles
// and one long output stall. The checker beside the unit scores every beat.
// ----------------------------------------------------------------------------
module testbench import datediff_pkg::*;;

  localparam int ITEMS_PER_PHASE = 430;
  localparam int BURST_ITEMS     = 12;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 40;
  localparam int STALL_LIMIT     = 4000;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [DAY_W-1:0]   day_a;
  logic [MONTH_W-1:0] month_a;
  logic [YEAR_W-1:0]  year_a;
  logic [DAY_W-1:0]   day_b;
  logic [MONTH_W-1:0] month_b;
  logic [YEAR_W-1:0]  year_b;
  logic               out_valid;
  logic               out_ready;
  logic [COUNT_W-1:0] day_count;

  int errors;
  int awaiting;
  int tx_idle_pct;
  int rx_idle_pct;
  bit rx_hold;
  bit hold_trigger;

  always #6 clk = ~clk;

  date_difference_days_unit i_dut (.*);

  date_difference_checker i_checker (.*);

  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // long output stall so the unit fills up and drops in_ready
  initial begin : receiver_hold_off
    rx_hold = 1'b0;
    @(posedge hold_trigger);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("testbench: errors");
    $finish;
  end

  // valid stays high after the beat until the next call decides
  task automatic send_dates(input int d_a, input int m_a, input int y_a,
                            input int d_b, input int m_b, input int y_b);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    day_a    <= DAY_W'(d_a);
    month_a  <= MONTH_W'(m_a);
    year_a   <= YEAR_W'(y_a);
    day_b    <= DAY_W'(d_b);
    month_b  <= MONTH_W'(m_b);
    year_b   <= YEAR_W'(y_b);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
  endtask

  task automatic random_dates(input int count);
    int d1, m1, y1, d2, m2, y2, kind;
    for (int n = 0; n < count; n++) begin
      y1 = $urandom_range(1, 9999);
      m1 = $urandom_range(1, 12);
      d1 = ($urandom_range(0, 9) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
      y2 = $urandom_range(1, 9999);
      m2 = $urandom_range(1, 12);
      d2 = ($urandom_range(0, 9) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        y2 = y1;
      end else if (kind < 45) begin
        y2 = y1 + int'($urandom_range(0, 4)) - 2;
        if (y2 < 1) y2 = 1;
      end else if (kind < 55) begin
        // end of february around century years
        y1 = 100 * int'($urandom_range(0, 99));
        y2 = 100 * int'($urandom_range(0, 99));
        m1 = 2;
        d1 = $urandom_range(28, 29);
        m2 = 3;
        d2 = 1;
      end else if (kind >= 85) begin
        d1 = $urandom_range(0, 31);
        m1 = $urandom_range(0, 15);
        y1 = $urandom_range(0, 16383);
        d2 = $urandom_range(0, 31);
        m2 = $urandom_range(0, 15);
        y2 = $urandom_range(0, 16383);
      end
      send_dates(d1, m1, y1, d2, m2, y2);
    end
  endtask

  initial begin : stimulus
    rst         = 1'b1;
    in_valid    = 1'b0;
    day_a       = '0;
    month_a     = '0;
    year_a      = '0;
    day_b       = '0;
    month_b     = '0;
    year_b      = '0;
    tx_idle_pct = 28;
    rx_idle_pct = 88;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_dates(29, 2, 2024, 29, 2, 2024);
    send_dates(0, 0, 0, 0, 0, 0);
    send_dates(31, 15, 16383, 31, 15, 16383);
    send_dates(1, 1, 1, 31, 12, 9999);
    send_dates(31, 12, 9999, 1, 1, 1);
    send_dates(1, 1, 0, 1, 1, 1);
    send_dates(0, 0, 0, 31, 15, 16383);
    send_dates(31, 15, 16383, 0, 0, 0);
    send_dates(10, 0, 2023, 10, 1, 2023);
    send_dates(5, 13, 2023, 5, 12, 2023);
    // raw key order and day-of-year order disagree
    send_dates(1, 15, 2023, 31, 12, 2023);
    send_dates(0, 2, 2023, 31, 2, 2023);
    send_dates(29, 2, 1900, 1, 3, 1900);
    send_dates(29, 2, 2000, 1, 3, 2000);
    send_dates(28, 2, 2100, 1, 3, 2100);
    send_dates(31, 12, 1999, 1, 1, 2000);
    send_dates(1, 3, 1900, 1, 3, 2000);
    send_dates(1, 1, 1600, 1, 1, 2400);
    send_dates(31, 12, 2024, 1, 1, 2024);
    send_dates(1, 1, 4096, 1, 1, 8192);
    send_dates(21, 10, 5461, 10, 5, 10922);
    random_dates(ITEMS_PER_PHASE);
    wait_drained();

    tx_idle_pct = 88;
    rx_idle_pct = 28;
    random_dates(ITEMS_PER_PHASE);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_trigger = 1'b1;
    random_dates(BURST_ITEMS);
    wait_drained();
    random_dates(ITEMS_PER_PHASE);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && awaiting == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
